>>> rtl/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg - shared types and codes of the graph bridge finder
// Table sizes, command codes, result kinds and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbf_pkg;

    // Table sizes
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;

    // Command codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BRIDGE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    // Search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_EDGE,
        S_DISC,
        S_POP
    } t_state;

endpackage

`default_nettype wire

>>> rtl/gbf_ram.sv
// ----------------------------------------------------------------------------
// gbf_ram - simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbf_ram
    import gbf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read beat
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/graph_bridge_finder.sv
// ----------------------------------------------------------------------------
// graph_bridge_finder - bridge search over a loaded edge table
// Loads edges, then runs an iterative depth-first low-link search.
// ----------------------------------------------------------------------------
// Clear and load commands are taken one per cycle while busy is low, and
// their single result appears on the following cycle. A run holds busy high
// for the whole search. It first walks the node table once to clear the
// visited marks. Then each node pushed scans every loaded edge, with one
// edge table read and one evaluate per edge, plus a visited mark and
// discovery time read for each edge that passes the skip tests; each pop
// reads and restores the parent frame. Busy is already low when the done
// beat is shown. The search pace is set by the single read port of the
// edge table. Results are one-cycle strobes on o_valid; the receiver must
// take every beat as it comes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module graph_bridge_finder
    import gbf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_op,
    input  wire logic [5:0] i_node_a,
    input  wire logic [5:0] i_node_b,
    input  wire logic       i_edge_locked,
    input  wire logic [5:0] i_start_node,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_bridge_edge,
    output logic [5:0]      o_child_node,
    output logic            o_last
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = EW + 1;
    localparam int DW = NW + 1;
    localparam int LW = (NW + 1 > 7) ? NW + 1 : 7;
    localparam int FW = 3 * NW + 2 * EW + 2;

    // Control and count registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_edges, n_edges;
    logic [6:0]      r_node_count;
    logic [NW-1:0]   r_u, n_u;
    logic [EW-1:0]   r_entry, n_entry;
    logic            r_has, n_has;
    logic [CW-1:0]   r_next, n_next;
    logic [NW-1:0]   r_disc, n_disc;
    logic [NW-1:0]   r_low, n_low;
    logic [EW-1:0]   r_cur_e, n_cur_e;
    logic [NW-1:0]   r_v, n_v;
    logic [NW-1:0]   r_clr, n_clr;
    logic [DW-1:0]   r_depth, n_depth;
    logic [DW-1:0]   r_timer, n_timer;
    logic [5:0]      r_nbr, n_nbr;
    logic            r_valid, n_valid;
    logic [1:0]      r_kind, n_kind;
    logic [7:0]      r_edge_o, n_edge_o;
    logic [5:0]      r_child, n_child;
    logic            r_last, n_last;

    // Memory ports
    logic            edge_we;
    logic [12:0]     edge_rd;
    logic            stk_we;
    logic [FW-1:0]   stk_rd;
    logic            disc_we;
    logic [NW:0]     disc_rd;

    // Decoded terms
    logic [LW-1:0]   w_lim;
    logic            w_start_ok;
    logic            w_more;
    logic [5:0]      w_a, w_b;
    logic            w_lk;
    logic            w_skip;
    logic [NW-1:0]   w_v;
    logic            w_vis;
    logic [NW-1:0]   w_dt;
    logic            w_can_push;
    logic            w_accept;
    logic            w_run_init;
    logic            w_push;
    logic [NW-1:0]   p_u;
    logic [EW-1:0]   p_entry;
    logic            p_has;
    logic [CW-1:0]   p_next;
    logic [NW-1:0]   p_disc;
    logic [NW-1:0]   p_low;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Effective node limit
    always_comb begin
        if (LW'(r_node_count) < LW'(MAX_NODES)) begin
            w_lim = LW'(r_node_count);
        end else begin
            w_lim = LW'(MAX_NODES);
        end
    end

    assign w_start_ok = LW'(i_start_node) < w_lim;
    assign w_more     = r_next < r_edges;
    assign w_can_push = r_depth < DW'(MAX_NODES);

    // Decode the fetched edge
    assign w_a  = edge_rd[5:0];
    assign w_b  = edge_rd[11:6];
    assign w_lk = edge_rd[12];
    assign w_skip = (r_has && (r_cur_e == r_entry)) || w_lk
                 || (LW'(w_a) >= w_lim) || (LW'(w_b) >= w_lim)
                 || ((LW'(w_a) != LW'(r_u)) && (LW'(w_b) != LW'(r_u)));
    assign w_v   = (LW'(w_a) == LW'(r_u)) ? NW'(w_b) : NW'(w_a);

    // Split the node entry into visited mark and discovery time
    assign w_vis = disc_rd[NW];
    assign w_dt  = disc_rd[NW-1:0];

    // Unpack the parent frame
    assign {p_u, p_entry, p_has, p_next, p_disc, p_low} = stk_rd;

    assign w_run_init = w_accept && (i_op == OP_RUN) && w_start_ok;
    assign w_push     = (r_state == S_DISC) && !w_vis && w_can_push;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_run_init) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_clr == NW'(MAX_NODES - 1)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (w_more) begin
                    n_state = S_EDGE;
                end else if (r_depth == DW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_EDGE: begin
                if (!w_skip) begin
                    n_state = S_DISC;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DISC:  n_state = S_FETCH;
            S_POP:   n_state = S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result beats
    always_comb begin
        n_edges  = r_edges;
        n_u      = r_u;
        n_entry  = r_entry;
        n_has    = r_has;
        n_next   = r_next;
        n_disc   = r_disc;
        n_low    = r_low;
        n_cur_e  = r_cur_e;
        n_v      = r_v;
        n_clr    = r_clr;
        n_depth  = r_depth;
        n_timer  = r_timer;
        n_nbr    = r_nbr;
        n_valid  = 1'b0;
        n_kind   = KIND_DONE;
        n_edge_o = '0;
        n_child  = '0;
        n_last   = 1'b1;
        edge_we  = 1'b0;
        stk_we   = 1'b0;
        disc_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        OP_CLEAR: begin
                            n_edges = '0;
                            n_valid = 1'b1;
                            n_kind  = KIND_ACK;
                        end
                        OP_LOAD: begin
                            n_valid = 1'b1;
                            if (r_edges == CW'(MAX_EDGES)) begin
                                n_kind = KIND_FULL;
                            end else begin
                                edge_we = 1'b1;
                                n_edges = r_edges + CW'(1);
                                n_kind  = KIND_ACK;
                            end
                        end
                        OP_RUN: begin
                            if (w_start_ok) begin
                                n_u     = NW'(i_start_node);
                                n_entry = '0;
                                n_has   = 1'b0;
                                n_next  = '0;
                                n_disc  = '0;
                                n_low   = '0;
                                n_clr   = '0;
                                n_timer = DW'(1);
                                n_depth = DW'(1);
                                n_nbr   = '0;
                            end else begin
                                n_valid = 1'b1;
                                n_kind  = KIND_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                disc_we = 1'b1;
                n_clr   = r_clr + NW'(1);
            end
            S_FETCH: begin
                if (w_more) begin
                    n_cur_e = r_next[EW-1:0];
                    n_next  = r_next + CW'(1);
                end else if (r_depth == DW'(1)) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_DONE;
                end
            end
            S_EDGE: begin
                n_v = w_v;
            end
            S_DISC: begin
                if (w_vis) begin
                    if (w_dt < r_low) begin
                        n_low = w_dt;
                    end
                end else if (w_push) begin
                    stk_we  = 1'b1;
                    disc_we = 1'b1;
                    n_u     = r_v;
                    n_entry = r_cur_e;
                    n_has   = 1'b1;
                    n_next  = '0;
                    n_disc  = NW'(r_timer);
                    n_low   = NW'(r_timer);
                    n_timer = r_timer + DW'(1);
                    n_depth = r_depth + DW'(1);
                end
            end
            S_POP: begin
                if ((r_low > p_disc) && (r_nbr != 6'd63)) begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_BRIDGE;
                    n_edge_o = 8'(r_entry);
                    n_child  = 6'(r_u);
                    n_last   = 1'b0;
                    n_nbr    = r_nbr + 6'd1;
                end
                n_u     = p_u;
                n_entry = p_entry;
                n_has   = p_has;
                n_next  = p_next;
                n_disc  = p_disc;
                n_low   = (r_low < p_low) ? r_low : p_low;
                n_depth = r_depth - DW'(1);
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edges      <= '0;
            r_node_count <= 7'd64;
            r_depth      <= '0;
            r_timer      <= '0;
            r_nbr        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edges <= n_edges;
            r_depth <= n_depth;
            r_timer <= n_timer;
            r_nbr   <= n_nbr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // Top frame and result payload
    always_ff @(posedge i_clk) begin
        r_u      <= n_u;
        r_entry  <= n_entry;
        r_has    <= n_has;
        r_next   <= n_next;
        r_disc   <= n_disc;
        r_low    <= n_low;
        r_cur_e  <= n_cur_e;
        r_v      <= n_v;
        r_clr    <= n_clr;
        r_kind   <= n_kind;
        r_edge_o <= n_edge_o;
        r_child  <= n_child;
        r_last   <= n_last;
    end

    // Edge table
    gbf_ram #(
        .WIDTH (13),
        .DEPTH (MAX_EDGES),
        .AW    (EW)
    ) u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edges[EW-1:0]),
        .i_wdata ({i_edge_locked, i_node_b, i_node_a}),
        .i_raddr (r_next[EW-1:0]),
        .o_rdata (edge_rd)
    );

    // Saved search frames below the top
    gbf_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_NODES),
        .AW    (NW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (NW'(r_depth - DW'(1))),
        .i_wdata ({r_u, r_entry, r_has, r_next, r_disc, r_low}),
        .i_raddr (NW'(r_depth - DW'(2))),
        .o_rdata (stk_rd)
    );

    // Visited marks and discovery times by node; the clear pass marks the root
    gbf_ram #(
        .WIDTH (NW + 1),
        .DEPTH (MAX_NODES),
        .AW    (NW)
    ) u_disc_mem (
        .i_clk   (i_clk),
        .i_we    (disc_we),
        .i_waddr ((r_state == S_CLEAR) ? r_clr : r_v),
        .i_wdata ((r_state == S_CLEAR) ? {(r_clr == r_u), NW'(0)}
                                       : {1'b1, NW'(r_timer)}),
        .i_raddr (w_v),
        .o_rdata (disc_rd)
    );

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_bridge_edge = r_edge_o;
    assign o_child_node  = r_child;
    assign o_last        = r_last;

    // A bridge beat is never the final beat of a run
    a_bridge_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_BRIDGE)) |-> !o_last)
        else $error("bridge beat marked last");

    // The done beat leaves the block ready for a command
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_DONE)) |-> !busy)
        else $error("done beat while busy");

    // A clear or load gives its beat on the next cycle
    a_load_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_op == OP_CLEAR) || (i_op == OP_LOAD))) |=> o_valid)
        else $error("missing clear or load beat");

    // Stack depth stays within the frame store
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_NODES))
        else $error("stack depth overflow");

endmodule

`default_nettype wire
